// File: hdl/cbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console buss saturation package
// Shared widths, fixed-point constants, divider handshake types and the
// reciprocal table used by the Taylor series sine.
// ----------------------------------------------------------------------------
package cbs_pkg;

    localparam int SAMPLE_BITS = 24;

    // Shared multiplier operands and product.
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // Divider widths: dividend, divisor and the quotient bits kept.
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 33;
    localparam int DIV_Q_W   = 32;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_TRIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASS_TRIM   = 2'd2;

    localparam logic [16:0] TARGET_RESET = 17'd65536;
    localparam logic [23:0] SERVO_RESET  = 24'd109951;
    localparam logic [23:0] BASS_RESET   = 24'd83886;

    // Fixed-point constants (Q30 signal, Q12.20 chase rate, Q40 servo).
    localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
    localparam logic signed [31:0] NEG_ONE_Q30 = -32'sd1073741824;
    localparam logic signed [31:0] HALF_PI_Q30 = 32'sd1686629713;
    localparam logic signed [31:0] NEG_HALF_PI = -32'sd1686629713;
    localparam logic [30:0]        HALF_PI_U   = 31'd1686629713;
    localparam logic [31:0] RATE_FLOOR     = 32'd367001600;
    localparam logic [31:0] RATE_CAP       = 32'd2621440000;
    localparam logic [31:0] RATE_DECAY_MUL = 32'd4294537799;
    localparam logic [31:0] RATE_DECAY_SUB = 32'd10486;
    localparam logic [19:0] SERVO_MUL      = 20'd549756;
    localparam logic signed [61:0] DC_LIMIT = 62'sd1 <<< 60;
    localparam logic signed [61:0] DC_NEG_LIMIT = -(62'sd1 <<< 60);

    // Output conversion from Q30 to the sample format.
    localparam int OUT_SHIFT = 32 - SAMPLE_BITS;
    localparam logic signed [33:0] OUT_ROUND =
        (OUT_SHIFT == 0) ? 34'sd0 : (34'sd1 <<< (OUT_SHIFT - 1));
    localparam logic signed [33:0] OUT_MAX = (34'sd1 <<< (SAMPLE_BITS - 1)) - 34'sd1;
    localparam logic signed [33:0] OUT_MIN = -(34'sd1 <<< (SAMPLE_BITS - 1));

    // Scaling of the sample by the Q30 gain back to Q30.
    localparam int SCALE_SHIFT = SAMPLE_BITS - 2;
    localparam logic signed [PROD_W-1:0] SCALE_ROUND =
        {{(PROD_W-1){1'b0}}, 1'b1} << (SAMPLE_BITS - 3);

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    // Taylor term divisor (2k)(2k+1) for term index k-1.
    function automatic logic [8:0] sin_div(input logic [2:0] k);
        logic [8:0] d;
        case (k)
            3'd0: d = 9'd6;
            3'd1: d = 9'd20;
            3'd2: d = 9'd42;
            3'd3: d = 9'd72;
            3'd4: d = 9'd110;
            3'd5: d = 9'd156;
            3'd6: d = 9'd210;
            default: d = 9'd272;
        endcase
        return d;
    endfunction

    // floor(2^34 / divisor); the quotient estimate is exact or one low.
    function automatic logic [31:0] sin_recip(input logic [2:0] k);
        logic [31:0] r;
        case (k)
            3'd0: r = 32'd2863311530;
            3'd1: r = 32'd858993459;
            3'd2: r = 32'd409044504;
            3'd3: r = 32'd238609294;
            3'd4: r = 32'd156180628;
            3'd5: r = 32'd110127366;
            3'd6: r = 32'd81808900;
            default: r = 32'd63161283;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/cbs_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiply with a registered product.
// ----------------------------------------------------------------------------
module cbs_mul (
    input  logic                                i_clk,
    input  logic signed [cbs_pkg::MUL_W-1:0]    i_a,
    input  logic signed [cbs_pkg::MUL_W-1:0]    i_b,
    output logic signed [cbs_pkg::PROD_W-1:0]   o_p
);

    logic signed [cbs_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// File: hdl/cbs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative divider
// Unsigned restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbs_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cbs_pkg::t_div_ctl                   i_ctl,
    input  logic [cbs_pkg::DIV_NUM_W-1:0]       i_num,
    input  logic [cbs_pkg::DIV_DEN_W-1:0]       i_den,
    output cbs_pkg::t_div_sts                   o_sts,
    output logic [cbs_pkg::DIV_Q_W-1:0]         o_quot
);

    logic [cbs_pkg::DIV_NUM_W-1:0] r_num;
    logic [cbs_pkg::DIV_DEN_W-1:0] r_rem;
    logic [cbs_pkg::DIV_DEN_W-1:0] r_den;
    logic [cbs_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [cbs_pkg::DIV_DEN_W:0]   w_shift;
    logic [cbs_pkg::DIV_DEN_W:0]   w_diff;
    logic                          w_ge;

    always_comb begin
        w_shift = {r_rem, r_num[cbs_pkg::DIV_NUM_W-1]};
        w_diff  = w_shift - {1'b0, r_den};
        w_ge    = (w_shift >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == {cbs_pkg::DIV_CNT_W{1'b1}}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[cbs_pkg::DIV_DEN_W-1:0] : w_shift[cbs_pkg::DIV_DEN_W-1:0];
            r_num <= {r_num[cbs_pkg::DIV_NUM_W-2:0], w_ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_num[cbs_pkg::DIV_Q_W-1:0];

endmodule

// File: hdl/console_buss_saturation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console buss saturation
// Gain smoothing, arcsine shaping, sine slew onto a stored buss value with a
// DC servo and bass trim, computed by a sequencer around shared units.
// ----------------------------------------------------------------------------
// Usage. Samples arrive on the input valid/ready channel as signed Q2.22
// words; one processed sample leaves on the output valid/ready channel for
// each input transaction, in order. The user must write the three configuration
// registers (target gain, servo trim, bass trim) through the plain write port
// only while the block is idle (not enforced); writes then take effect on the next sample.
//
// Sequencing. The input is not ready from an input transaction until that
// sample's result is written to the output register. Most of the time per
// sample goes to the arcsine bisection: about 31 sine evaluations, every
// Taylor term passing twice through the one shared multiplier, with the
// gain divide ahead of it.
//
// Reset restores all but the working registers: the chase rate sits at its
// floor and the first sample loads the smoothed gain from the target.
// A result waits in the output register while the receiver stalls; the next
// input transaction is still taken, and that sample's result is held back
// only if the earlier one has not been taken when it is finished.
// ----------------------------------------------------------------------------
module console_buss_saturation (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [cbs_pkg::SAMPLE_BITS-1:0] i_in_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [cbs_pkg::SAMPLE_BITS-1:0] o_out_sample,
    input  logic                                   i_cfg_we,
    input  logic [cbs_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [cbs_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int SB = cbs_pkg::SAMPLE_BITS;
    localparam int MW = cbs_pkg::MUL_W;
    localparam int PW = cbs_pkg::PROD_W;

    localparam logic signed [PW-1:0] RND29 = {{(PW-1){1'b0}}, 1'b1} << 29;
    localparam logic signed [PW-1:0] RND23 = {{(PW-1){1'b0}}, 1'b1} << 23;
    localparam logic signed [PW-1:0] ONE_P = {{(PW-1){1'b0}}, 1'b1} << 30;
    localparam logic signed [PW-1:0] NEG_ONE_P = -ONE_P;

    localparam logic RET_ASIN = 1'b0;
    localparam logic RET_SLEW = 1'b1;

    // Sequencer states.
    localparam logic [5:0] S_IDLE      = 6'd0;
    localparam logic [5:0] S_RATE_MUL  = 6'd1;
    localparam logic [5:0] S_RATE_UPD  = 6'd2;
    localparam logic [5:0] S_GAIN_MUL  = 6'd3;
    localparam logic [5:0] S_GAIN_DIV  = 6'd4;
    localparam logic [5:0] S_GAIN_WAIT = 6'd5;
    localparam logic [5:0] S_SCALE_MUL = 6'd6;
    localparam logic [5:0] S_SCALE     = 6'd7;
    localparam logic [5:0] S_BIS_CHECK = 6'd8;
    localparam logic [5:0] S_BIS_RET   = 6'd9;
    localparam logic [5:0] S_SIN_Y2    = 6'd10;
    localparam logic [5:0] S_SIN_Y2R   = 6'd11;
    localparam logic [5:0] S_SIN_T     = 6'd12;
    localparam logic [5:0] S_SIN_TR    = 6'd13;
    localparam logic [5:0] S_SIN_Q     = 6'd14;
    localparam logic [5:0] S_SIN_QR    = 6'd15;
    localparam logic [5:0] S_SIN_FIX   = 6'd16;
    localparam logic [5:0] S_SLEW      = 6'd17;
    localparam logic [5:0] S_SLEW_RET  = 6'd18;
    localparam logic [5:0] S_DC_ACC    = 6'd19;
    localparam logic [5:0] S_OM        = 6'd20;
    localparam logic [5:0] S_NZ_MUL    = 6'd21;
    localparam logic [5:0] S_NZ_R      = 6'd22;
    localparam logic [5:0] S_HH_MUL    = 6'd23;
    localparam logic [5:0] S_HH_R      = 6'd24;
    localparam logic [5:0] S_HL_MUL    = 6'd25;
    localparam logic [5:0] S_HL_R      = 6'd26;
    localparam logic [5:0] S_LO_MUL    = 6'd27;
    localparam logic [5:0] S_LO_R      = 6'd28;
    localparam logic [5:0] S_BASS_MUL  = 6'd29;
    localparam logic [5:0] S_BASS_R    = 6'd30;
    localparam logic [5:0] S_FAC_MUL   = 6'd31;
    localparam logic [5:0] S_FAC_R     = 6'd32;
    localparam logic [5:0] S_OUT       = 6'd33;

    logic [5:0] r_state;
    logic [5:0] n_state;

    // Configuration registers.
    logic [16:0] r_target;
    logic [23:0] r_servo;
    logic [23:0] r_bass;

    // Architectural state carried from sample to sample.
    logic [16:0]        r_seen_gain;
    logic               r_seen_valid;
    logic [31:0]        r_chase;
    logic [30:0]        r_smooth;
    logic signed [31:0] r_stored;
    logic signed [31:0] r_prev;
    logic signed [61:0] r_dc;

    // Working registers for one sample.
    logic signed [SB-1:0] r_x;
    logic [30:0]          r_ax;
    logic                 r_neg;
    logic [30:0]          r_lo;
    logic [30:0]          r_hi;
    logic signed [31:0]   r_y;
    logic [31:0]          r_y2;
    logic signed [32:0]   r_term;
    logic signed [32:0]   r_sum;
    logic [31:0]          r_tmag;
    logic                 r_tneg;
    logic [29:0]          r_q0;
    logic [2:0]           r_k;
    logic                 r_ret;
    logic signed [31:0]   r_shaped;
    logic signed [33:0]   r_d;
    logic [30:0]          r_om;
    logic [30:0]          r_nz;
    logic signed [63:0]   r_acc;
    logic signed [31:0]   r_factor;

    logic                 r_out_valid;
    logic signed [SB-1:0] r_out_sample;

    // Shared units.
    logic signed [MW-1:0] w_ma;
    logic signed [MW-1:0] w_mb;
    logic signed [PW-1:0] w_prod;

    cbs_pkg::t_div_ctl                w_div_ctl;
    cbs_pkg::t_div_sts                w_div_sts;
    logic [cbs_pkg::DIV_NUM_W-1:0]    w_div_num;
    logic [cbs_pkg::DIV_DEN_W-1:0]    w_div_den;
    logic [cbs_pkg::DIV_Q_W-1:0]      w_div_quot;

    // Datapath intermediates.
    logic               w_accept;
    logic               w_changed;
    logic [32:0]        w_chase2;
    logic [31:0]        w_dec;
    logic [31:0]        w_dec_sub;
    logic signed [PW-1:0] w_sv;
    logic [30:0]        w_ax;
    logic [30:0]        w_span;
    logic [30:0]        w_mid;
    logic signed [PW-1:0] w_rnd30;
    logic signed [PW-1:0] w_tabs;
    logic [38:0]        w_qd;
    logic [32:0]        w_rem;
    logic [30:0]        w_q;
    logic signed [32:0] w_term_new;
    logic signed [32:0] w_diff;
    logic signed [31:0] w_diff_c;
    logic signed [34:0] w_err;
    logic signed [62:0] w_dc_sum;
    logic signed [31:0] w_stored_c;
    logic [31:0]        w_mag;
    logic signed [63:0] w_lo_sum;
    logic signed [63:0] w_add;
    logic signed [PW-1:0] w_bass_sh;
    logic signed [33:0] w_ov;

    assign w_accept = i_in_valid && o_in_ready;

    cbs_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    cbs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_sts   (w_div_sts),
        .o_quot  (w_div_quot)
    );

    // Operand selection for the shared multiplier; the product is read in
    // the state that follows.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_RATE_MUL: begin
                w_ma = $signed({1'b0, r_chase});
                w_mb = $signed({1'b0, cbs_pkg::RATE_DECAY_MUL});
            end
            S_GAIN_MUL: begin
                w_ma = $signed({2'b0, r_smooth});
                w_mb = $signed({1'b0, r_chase});
            end
            S_SCALE_MUL: begin
                w_ma = $signed({{(MW-SB){r_x[SB-1]}}, r_x});
                w_mb = $signed({2'b0, r_smooth});
            end
            S_SIN_Y2: begin
                w_ma = $signed({r_y[31], r_y});
                w_mb = $signed({r_y[31], r_y});
            end
            S_SIN_T: begin
                w_ma = r_term;
                w_mb = $signed({1'b0, r_y2});
            end
            S_SIN_Q: begin
                w_ma = $signed({1'b0, r_tmag});
                w_mb = $signed({1'b0, cbs_pkg::sin_recip(r_k)});
            end
            S_NZ_MUL: begin
                w_ma = $signed({2'b0, r_om});
                w_mb = $signed({2'b0, r_om});
            end
            S_HH_MUL: begin
                w_ma = $signed({{11{r_dc[61]}}, r_dc[61:40]});
                w_mb = $signed({13'b0, cbs_pkg::SERVO_MUL});
            end
            S_HL_MUL: begin
                w_ma = $signed({13'b0, r_dc[39:20]});
                w_mb = $signed({13'b0, cbs_pkg::SERVO_MUL});
            end
            S_LO_MUL: begin
                w_ma = $signed({13'b0, r_dc[19:0]});
                w_mb = $signed({13'b0, cbs_pkg::SERVO_MUL});
            end
            S_BASS_MUL: begin
                w_ma = $signed({2'b0, r_nz});
                w_mb = $signed({9'b0, r_bass});
            end
            S_FAC_MUL: begin
                w_ma = $signed({r_stored[31], r_stored});
                w_mb = $signed({r_factor[31], r_factor});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // Gain smoothing divide: (smoothed * rate + target * 2^20 + den / 2) / den.
    always_comb begin
        w_div_ctl.start = (r_state == S_GAIN_DIV);
        w_div_den = {1'b0, r_chase} + 33'd1048576;
        w_div_num = w_prod[63:0] + {13'b0, r_target, 34'b0} + {32'b0, w_div_den[32:1]};
    end

    always_comb begin
        // A new target, or the first sample, doubles the chase rate.
        w_changed = !r_seen_valid || (r_seen_gain != r_target);
        w_chase2  = w_changed ? {r_chase, 1'b0} : {1'b0, r_chase};

        w_dec     = w_prod[63:32];
        w_dec_sub = (w_dec > cbs_pkg::RATE_DECAY_SUB) ? w_dec - cbs_pkg::RATE_DECAY_SUB : '0;

        // Scaled input, clamped to unity; magnitude goes to the bisection.
        w_sv = (w_prod + cbs_pkg::SCALE_ROUND) >>> cbs_pkg::SCALE_SHIFT;
        if (w_sv > ONE_P) begin
            w_ax = cbs_pkg::ONE_Q30[30:0];
        end else if (w_sv < NEG_ONE_P) begin
            w_ax = cbs_pkg::ONE_Q30[30:0];
        end else if (w_sv[PW-1]) begin
            w_ax = w_tabs_sv(w_sv);
        end else begin
            w_ax = w_sv[30:0];
        end

        w_span = r_hi - r_lo + 31'd1;
        w_mid  = r_lo + {1'b0, w_span[30:1]};

        w_rnd30 = (w_prod + RND29) >>> 30;
        w_tabs  = w_rnd30[PW-1] ? -w_rnd30 : w_rnd30;

        // Quotient estimate is exact or one low; one compare fixes it.
        w_qd = r_q0 * cbs_pkg::sin_div(r_k);
        w_rem = {1'b0, r_tmag} - w_qd[32:0];
        w_q = {1'b0, r_q0} + {30'b0, (w_rem >= {24'b0, cbs_pkg::sin_div(r_k)})};
        w_term_new = r_tneg ? $signed({2'b0, w_q}) : -$signed({2'b0, w_q});

        w_diff = $signed({r_prev[31], r_prev}) - $signed({r_shaped[31], r_shaped});
        if (w_diff > cbs_pkg::HALF_PI_Q30) begin
            w_diff_c = cbs_pkg::HALF_PI_Q30;
        end else if (w_diff < cbs_pkg::NEG_HALF_PI) begin
            w_diff_c = cbs_pkg::NEG_HALF_PI;
        end else begin
            w_diff_c = w_diff[31:0];
        end

        w_err = $signed({{3{r_shaped[31]}}, r_shaped}) - $signed({r_d[33], r_d});
        w_dc_sum = $signed({r_dc[61], r_dc}) + $signed({{18{w_err[34]}}, w_err, 10'b0});

        if (r_d > cbs_pkg::ONE_Q30) begin
            w_stored_c = cbs_pkg::ONE_Q30;
        end else if (r_d < cbs_pkg::NEG_ONE_Q30) begin
            w_stored_c = cbs_pkg::NEG_ONE_Q30;
        end else begin
            w_stored_c = r_d[31:0];
        end

        w_mag = r_stored[31] ? 32'(-r_stored) : r_stored;

        w_lo_sum = r_acc + $signed({20'b0, w_prod[63:20]});
        w_add    = w_lo_sum >>> 30;

        w_bass_sh = (w_prod + RND23) >>> 24;

        w_ov = (r_d + cbs_pkg::OUT_ROUND) >>> cbs_pkg::OUT_SHIFT;
    end

    function automatic logic [30:0] w_tabs_sv(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] n;
        n = -v;
        return n[30:0];
    endfunction

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (w_accept) n_state = S_RATE_MUL;
            S_RATE_MUL:  n_state = S_RATE_UPD;
            S_RATE_UPD:  n_state = S_GAIN_MUL;
            S_GAIN_MUL:  n_state = S_GAIN_DIV;
            S_GAIN_DIV:  n_state = S_GAIN_WAIT;
            S_GAIN_WAIT: if (w_div_sts.done) n_state = S_SCALE_MUL;
            S_SCALE_MUL: n_state = S_SCALE;
            S_SCALE:     n_state = S_BIS_CHECK;
            S_BIS_CHECK: n_state = (r_lo < r_hi) ? S_SIN_Y2 : S_SLEW;
            S_BIS_RET:   n_state = S_BIS_CHECK;
            S_SIN_Y2:    n_state = S_SIN_Y2R;
            S_SIN_Y2R:   n_state = S_SIN_T;
            S_SIN_T:     n_state = S_SIN_TR;
            S_SIN_TR:    n_state = S_SIN_Q;
            S_SIN_Q:     n_state = S_SIN_QR;
            S_SIN_QR:    n_state = S_SIN_FIX;
            S_SIN_FIX: begin
                if (r_k == 3'd7) begin
                    n_state = (r_ret == RET_SLEW) ? S_SLEW_RET : S_BIS_RET;
                end else begin
                    n_state = S_SIN_T;
                end
            end
            S_SLEW:      n_state = S_SIN_Y2;
            S_SLEW_RET:  n_state = S_DC_ACC;
            S_DC_ACC:    n_state = S_OM;
            S_OM:        n_state = S_NZ_MUL;
            S_NZ_MUL:    n_state = S_NZ_R;
            S_NZ_R:      n_state = S_HH_MUL;
            S_HH_MUL:    n_state = S_HH_R;
            S_HH_R:      n_state = S_HL_MUL;
            S_HL_MUL:    n_state = S_HL_R;
            S_HL_R:      n_state = S_LO_MUL;
            S_LO_MUL:    n_state = S_LO_R;
            S_LO_R:      n_state = S_BASS_MUL;
            S_BASS_MUL:  n_state = S_BASS_R;
            S_BASS_R:    n_state = S_FAC_MUL;
            S_FAC_MUL:   n_state = S_FAC_R;
            S_FAC_R:     n_state = S_OUT;
            S_OUT:       if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= cbs_pkg::TARGET_RESET;
            r_servo  <= cbs_pkg::SERVO_RESET;
            r_bass   <= cbs_pkg::BASS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cbs_pkg::CFG_TARGET_GAIN: r_target <= i_cfg_data[16:0];
                cbs_pkg::CFG_SERVO_TRIM:  r_servo  <= i_cfg_data;
                cbs_pkg::CFG_BASS_TRIM:   r_bass   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // State that persists across samples.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_seen_gain  <= '0;
            r_seen_valid <= 1'b0;
            r_chase      <= cbs_pkg::RATE_FLOOR;
            r_smooth     <= '0;
            r_stored     <= '0;
            r_prev       <= '0;
            r_dc         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_chase <= (w_chase2 > {1'b0, cbs_pkg::RATE_CAP}) ?
                                   cbs_pkg::RATE_CAP : w_chase2[31:0];
                        r_seen_gain  <= r_target;
                        r_seen_valid <= 1'b1;
                        if (!r_seen_valid) begin
                            r_smooth <= {r_target, 14'b0};
                        end
                    end
                end
                S_RATE_UPD: begin
                    r_chase <= (w_dec_sub < cbs_pkg::RATE_FLOOR) ?
                               cbs_pkg::RATE_FLOOR : w_dec_sub;
                end
                S_GAIN_WAIT: begin
                    if (w_div_sts.done) begin
                        r_smooth <= w_div_quot[30:0];
                    end
                end
                S_SLEW: begin
                    r_prev <= r_shaped;
                end
                S_DC_ACC: begin
                    // Servo accumulator saturates at plus or minus 2^60.
                    if (w_dc_sum > cbs_pkg::DC_LIMIT) begin
                        r_dc <= cbs_pkg::DC_LIMIT;
                    end else if (w_dc_sum < cbs_pkg::DC_NEG_LIMIT) begin
                        r_dc <= cbs_pkg::DC_NEG_LIMIT;
                    end else begin
                        r_dc <= w_dc_sum[61:0];
                    end
                    r_stored <= w_stored_c;
                end
                S_OM: begin
                    if (r_dc > 62'sd0) begin
                        r_dc <= r_dc - $signed({38'b0, r_servo});
                    end
                end
                S_NZ_MUL: begin
                    // Second decay test sees the result of the first.
                    if (r_dc < 62'sd0) begin
                        r_dc <= r_dc + $signed({38'b0, r_servo});
                    end
                end
                S_LO_R: begin
                    r_stored <= r_stored + w_add[31:0];
                end
                S_FAC_R: begin
                    r_stored <= w_rnd30[31:0];
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Per-sample working registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_x <= i_in_sample;
                end
            end
            S_SCALE: begin
                r_ax  <= w_ax;
                r_neg <= w_sv[PW-1];
                r_lo  <= '0;
                r_hi  <= cbs_pkg::HALF_PI_U;
            end
            S_BIS_CHECK: begin
                if (r_lo < r_hi) begin
                    r_y   <= $signed({1'b0, w_mid});
                    r_ret <= RET_ASIN;
                end else begin
                    r_shaped <= r_neg ? -$signed({1'b0, r_lo}) : $signed({1'b0, r_lo});
                end
            end
            S_BIS_RET: begin
                if (r_sum <= $signed({2'b0, r_ax})) begin
                    r_lo <= r_y[30:0];
                end else begin
                    r_hi <= r_y[30:0] - 31'd1;
                end
            end
            S_SIN_Y2R: begin
                r_y2   <= w_rnd30[31:0];
                r_term <= $signed({r_y[31], r_y});
                r_sum  <= $signed({r_y[31], r_y});
                r_k    <= '0;
            end
            S_SIN_TR: begin
                r_tneg <= w_rnd30[PW-1];
                r_tmag <= w_tabs[31:0];
            end
            S_SIN_QR: begin
                r_q0 <= w_prod[63:34];
            end
            S_SIN_FIX: begin
                r_term <= w_term_new;
                r_sum  <= r_sum + w_term_new;
                r_k    <= r_k + 3'd1;
            end
            S_SLEW: begin
                r_y   <= w_diff_c;
                r_ret <= RET_SLEW;
            end
            S_SLEW_RET: begin
                r_d <= $signed({{2{r_stored[31]}}, r_stored}) + $signed({r_sum[32], r_sum});
            end
            S_OM: begin
                r_om <= cbs_pkg::ONE_Q30[30:0] - w_mag[30:0];
            end
            S_NZ_R: begin
                r_nz <= w_rnd30[30:0];
            end
            S_HH_R: begin
                r_acc <= $signed(w_prod[63:0]);
            end
            S_HL_R: begin
                r_acc <= (r_acc <<< 20) + $signed(w_prod[63:0]);
            end
            S_BASS_R: begin
                r_factor <= cbs_pkg::ONE_Q30 - w_bass_sh[31:0];
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    if (w_ov > cbs_pkg::OUT_MAX) begin
                        r_out_sample <= cbs_pkg::OUT_MAX[SB-1:0];
                    end else if (w_ov < cbs_pkg::OUT_MIN) begin
                        r_out_sample <= cbs_pkg::OUT_MIN[SB-1:0];
                    end else begin
                        r_out_sample <= w_ov[SB-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;

    // A taken sample keeps the input closed on the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("input ready right after a transaction");

    // The chase rate stays between its floor and its cap between samples.
    a_chase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
            (r_chase >= cbs_pkg::RATE_FLOOR && r_chase <= cbs_pkg::RATE_CAP))
        else $error("chase rate out of range");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (r_state == S_GAIN_WAIT))
        else $error("divider finished outside its wait state");

endmodule
